### rtl/qmi_pkg.sv
`timescale 1ns / 1ps

package qmi_pkg;

  localparam int CAPACITY    = 1024;
  localparam int VALUE_WIDTH = 31;
  localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LEN_W       = $clog2(CAPACITY + 1);

  localparam logic [1:0] OP_PUSH_TAIL   = 2'd0;
  localparam logic [1:0] OP_PUSH_MIDDLE = 2'd1;
  localparam logic [1:0] OP_POP_FRONT   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [LEN_W-1:0]       len_t;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_APPEND,
    CMD_INSERT,
    CMD_SHIFT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    idx_t      pos;
    value_t    value;
  } cmd_t;

endpackage

### rtl/qmi_req_if.sv
`timescale 1ns / 1ps

interface qmi_req_if;
  import qmi_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] operation;
  value_t     value;

  modport source (output valid, output operation, output value, input ready);
  modport sink (input valid, input operation, input value, output ready);
endinterface

### rtl/qmi_rsp_if.sv
`timescale 1ns / 1ps

interface qmi_rsp_if;
  import qmi_pkg::*;

  logic       valid;
  logic       ready;
  value_t     popped_value;
  logic [1:0] status;

  modport source (output valid, output popped_value, output status, input ready);
  modport sink (input valid, input popped_value, input status, output ready);
endinterface

### rtl/qmi_cell.sv
`timescale 1ns / 1ps

module qmi_cell (
  input  logic            clk,
  input  qmi_pkg::idx_t   idx,
  input  qmi_pkg::cmd_t   cmd,
  input  qmi_pkg::value_t left,
  input  qmi_pkg::value_t right,
  output qmi_pkg::value_t data
);
  import qmi_pkg::*;

  value_t data_next;

  always_comb begin
    data_next = data;
    unique case (cmd.kind)
      CMD_HOLD:   data_next = data;
      CMD_APPEND: begin
        if (idx == cmd.pos) data_next = cmd.value;
      end
      CMD_INSERT: begin
        if (idx == cmd.pos) begin
          data_next = cmd.value;
        end else if (idx > cmd.pos) begin
          data_next = left;
        end
      end
      CMD_SHIFT:  data_next = right;
      default:    data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

### rtl/qmi_chain.sv
`timescale 1ns / 1ps

module qmi_chain (
  input  logic            clk,
  input  qmi_pkg::cmd_t   cmd,
  output qmi_pkg::value_t head
);
  import qmi_pkg::*;

  value_t cell_data [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    value_t left_in;
    value_t right_in;

    if (i == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_mid_left
      assign left_in = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_mid_right
      assign right_in = cell_data[i+1];
    end

    qmi_cell u_cell (
      .clk   (clk),
      .idx   (IDX_W'(i)),
      .cmd   (cmd),
      .left  (left_in),
      .right (right_in),
      .data  (cell_data[i])
    );
  end

  assign head = cell_data[0];

endmodule

### rtl/queue_with_middle_insert.sv
`timescale 1ns / 1ps
// Result: the result of an item is registered and shown in the cycle after it is accepted.
// Throughput: one item per cycle while no result is held; every cell of the
// row updates in the same cycle from the broadcast command and its neighbors,
// and a held result in the output register stalls the input until it is taken.
// Reset: synchronous, active high; empties the queue and clears the output valid.

module queue_with_middle_insert (
  input logic       clk,
  input logic       rst,
  qmi_req_if.sink   req,
  qmi_rsp_if.source rsp
);
  import qmi_pkg::*;

  len_t       len;
  len_t       len_next;
  len_t       mid_sum;
  cmd_t       cmd;
  value_t     head;
  value_t     popped_next;
  logic [1:0] status_next;
  logic       accept;
  logic       rsp_valid;
  value_t     rsp_popped;
  logic [1:0] rsp_status;

  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign mid_sum   = len + LEN_W'(1);

  always_comb begin
    cmd.kind    = CMD_HOLD;
    cmd.pos     = IDX_W'(len);
    cmd.value   = req.value;
    len_next    = len;
    popped_next = '0;
    status_next = ST_OK;
    case (req.operation)
      OP_PUSH_TAIL, OP_PUSH_MIDDLE: begin
        if (len == LEN_W'(CAPACITY)) begin
          status_next = ST_FULL;
        end else begin
          len_next = len + LEN_W'(1);
          if (req.operation == OP_PUSH_TAIL) begin
            cmd.kind = CMD_APPEND;
          end else begin
            cmd.kind = CMD_INSERT;
            cmd.pos  = IDX_W'(mid_sum >> 1);
          end
        end
      end
      OP_POP_FRONT: begin
        if (len == '0) begin
          status_next = ST_EMPTY;
        end else begin
          cmd.kind    = CMD_SHIFT;
          popped_next = head;
          len_next    = len - LEN_W'(1);
        end
      end
      default: ;
    endcase
    if (!accept) begin
      cmd.kind = CMD_HOLD;
      len_next = len;
    end
  end

  qmi_chain u_chain (
    .clk  (clk),
    .cmd  (cmd),
    .head (head)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      len       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      len <= len_next;
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_popped <= popped_next;
      rsp_status <= status_next;
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.popped_value = rsp_popped;
  assign rsp.status       = rsp_status;

endmodule

### rtl/qmi_check.sv
`timescale 1ns / 1ps

module qmi_check (
  input logic            clk,
  input logic            rst,
  input logic            req_valid,
  input logic            req_ready,
  input logic [1:0]      req_operation,
  input logic            rsp_valid,
  input logic            rsp_ready,
  input qmi_pkg::value_t rsp_popped_value,
  input logic [1:0]      rsp_status
);
  import qmi_pkg::*;

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> rsp_valid)
    else $error("accepted item gave no result");

  a_push_pops_nothing: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_operation != OP_POP_FRONT |=> rsp_popped_value == '0)
    else $error("non-pop item returned a value");

  a_failed_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != ST_OK |-> rsp_popped_value == '0)
    else $error("failed item returned a value");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
      && $stable(rsp_popped_value))
    else $error("stalled result changed");

  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> req_ready)
    else $error("input stalled with empty output");

endmodule

bind queue_with_middle_insert qmi_check u_qmi_check (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .req_operation    (req.operation),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_popped_value (rsp.popped_value),
  .rsp_status       (rsp.status)
);

### tb/sv/tb_queue_with_middle_insert.sv
`timescale 1ns / 1ps

module tb_queue_with_middle_insert;
  import qmi_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int BACKPRESSURE_CYCLES = 300;

  typedef struct {
    value_t     popped_value;
    logic [1:0] status;
  } queue_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic rx_ready = 1'b0;

  qmi_req_if req ();
  qmi_rsp_if rsp ();

  assign rsp.ready = rx_ready;

  queue_with_middle_insert dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  value_t        queue_contents[$];
  queue_result_t pending_results[$];
  int            error_count = 0;
  bit            idle_on = 1'b1;
  int            long_hold = 0;
  int            rx_gap = 0;
  int            stuck_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic queue_result_t predict_queue_result(logic [1:0] op, value_t val);
    queue_result_t res;
    int            n;
    n = queue_contents.size();
    res.popped_value = '0;
    res.status = ST_OK;
    case (op)
      OP_PUSH_TAIL, OP_PUSH_MIDDLE: begin
        if (n >= CAPACITY) begin
          res.status = ST_FULL;
        end else if (op == OP_PUSH_TAIL) begin
          queue_contents.push_back(val);
        end else begin
          queue_contents.insert((n + 1) / 2, val);
        end
      end
      OP_POP_FRONT: begin
        if (n == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.popped_value = queue_contents.pop_front();
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic logic [1:0] pick_operation(int pop_weight);
    int r;
    r = $urandom_range(0, 99);
    if (r < pop_weight) return OP_POP_FRONT;
    if (r < pop_weight + (96 - pop_weight) / 2) return OP_PUSH_TAIL;
    if (r < 96) return OP_PUSH_MIDDLE;
    return OP_UNUSED;
  endfunction

  function automatic value_t pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return value_t'($urandom);
  endfunction

  task automatic send_item(input logic [1:0] op, input value_t val);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.operation <= op;
    req.value <= val;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    pending_results.push_back(predict_queue_result(op, val));
  endtask

  task automatic send_random(int count, int pop_weight);
    for (int i = 0; i < count; i++) begin
      send_item(pick_operation(pop_weight), pick_value());
    end
  endtask

  task automatic test_directed_cases();
    send_item(OP_POP_FRONT, 31'h5555_5555);
    send_item(OP_UNUSED, '1);
    send_item(OP_PUSH_MIDDLE, '1);
    send_item(OP_PUSH_TAIL, '0);
    send_item(OP_PUSH_MIDDLE, 31'h2AAA_AAAA);
    send_item(OP_PUSH_MIDDLE, 31'h5555_5555);
    send_item(OP_PUSH_TAIL, 31'h0000_0001);
    send_item(OP_PUSH_MIDDLE, 31'h4000_0000);
    send_item(OP_UNUSED, '0);
    for (int i = 0; i < 7; i++) begin
      send_item(OP_POP_FRONT, '1);
    end
    send_item(OP_POP_FRONT, '0);
    send_item(OP_PUSH_TAIL, '1);
    send_item(OP_PUSH_TAIL, 31'h1234_5678);
    send_item(OP_PUSH_MIDDLE, 31'h0ABC_DEF0);
    send_item(OP_POP_FRONT, '0);
    send_item(OP_POP_FRONT, '0);
    send_item(OP_POP_FRONT, '0);
  endtask

  task automatic test_random_mix();
    for (int seg = 0; seg < 6; seg++) begin
      send_random(50, (seg % 2 == 0) ? 35 : 62);
    end
  endtask

  task automatic test_output_backpressure();
    long_hold = BACKPRESSURE_CYCLES;
    send_random(40, 40);
  endtask

  task automatic test_fill_to_full();
    while (queue_contents.size() < CAPACITY) begin
      send_item(($urandom_range(0, 1) == 0) ? OP_PUSH_TAIL : OP_PUSH_MIDDLE, pick_value());
    end
    send_item(OP_PUSH_TAIL, '1);
    send_item(OP_PUSH_MIDDLE, '0);
    send_item(OP_UNUSED, '1);
    send_item(OP_POP_FRONT, '0);
    send_item(OP_PUSH_MIDDLE, 31'h3C3C_3C3C);
    send_item(OP_PUSH_MIDDLE, 31'h4343_4343);
    send_item(OP_POP_FRONT, '0);
    send_item(OP_PUSH_TAIL, 31'h7FFF_0000);
    send_item(OP_PUSH_TAIL, 31'h0000_FFFF);
  endtask

  task automatic test_no_idle_tail();
    idle_on = 1'b0;
    send_random(60, 60);
  endtask

  always @(posedge clk) begin
    if (!rst && rsp.valid && rx_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result popped_value %0h status %0d", $time,
                 rsp.popped_value, rsp.status);
        error_count++;
      end else begin
        if (rsp.popped_value !== pending_results[0].popped_value) begin
          $display("%0t: popped_value expected %0h actual %0h", $time,
                   pending_results[0].popped_value, rsp.popped_value);
          error_count++;
        end
        if (rsp.status !== pending_results[0].status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   pending_results[0].status, rsp.status);
          error_count++;
        end
        void'(pending_results.pop_front());
      end
    end
    if (long_hold > 0) begin
      rx_ready <= 1'b0;
      long_hold--;
    end else if (rx_gap > 0) begin
      rx_ready <= 1'b0;
      rx_gap--;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      rx_ready <= 1'b0;
      rx_gap = $urandom_range(1, 18) - 1;
    end else begin
      rx_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rx_ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    req.valid <= 1'b0;
    req.operation <= OP_PUSH_TAIL;
    req.value <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_random_mix();
    test_output_backpressure();
    test_fill_to_full();
    test_no_idle_tail();
    req.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
